[src/spec_pkg.sv]
package spec_pkg;

  // pipeline layout
  localparam int PIPE_STG  = 30;   // register stages ahead of the output register
  localparam int CORR_STG  = 23;   // stages spent in the chroma correction
  localparam int DIV_BITS  = 19;   // quotient bits produced by the divider

  typedef logic signed [18:0] ct_t;  // corrected chroma, signed Q11.8

  // full-range ycbcr conversion, q16 coefficients
  localparam int unsigned Y_R        = 19595;
  localparam int unsigned Y_G        = 38470;
  localparam int unsigned Y_B        = 7471;
  localparam int unsigned CB_R       = 11058;
  localparam int unsigned CB_G       = 21710;
  localparam int unsigned CR_G       = 27439;
  localparam int unsigned CR_B       = 5329;
  localparam int unsigned CHROMA_OFS = 8388608;

  // luma band in which chroma passes uncorrected
  localparam logic [7:0] LUMA_LO = 8'd125;
  localparam logic [7:0] LUMA_HI = 8'd188;
  localparam logic [7:0] SPREAD_LO_REF = 8'd16;
  localparam logic [7:0] SPREAD_HI_REF = 8'd235;
  localparam int DEN_LO = 109;
  localparam int DEN_HI = 47;

  // per lane constants, lane 0 is cb and lane 1 is cr
  localparam int LANE_W      [2] = '{4697, 3876};
  localparam int LANE_K      [2] = '{108, 154};
  localparam int CN0_LO      [2] = '{11772, 16786};
  localparam int CNS_LO      [2] = '{10, -10};
  localparam int CN0_HI      [2] = '{5076, 7238};
  localparam int CNS_HI      [2] = '{10, 22};
  localparam int SN0_LO      [2] = '{250700, 218000};
  localparam int SNS_LO      [2] = '{2397, 1876};
  localparam int SN0_HI      [2] = '{65800, 47000};
  localparam int SNS_HI      [2] = '{3297, 2876};

  localparam int CT_MAX = 262143;
  localparam int CT_MIN = -262144;

  // rotation and ellipse
  localparam int CEN_B   = 28001;
  localparam int CEN_R   = 38917;
  localparam int ROT_COS = 13414;  // magnitude, the cosine is negative
  localparam int ROT_SIN = 9407;
  localparam int OFS_X   = 410;
  localparam int OFS_Y   = 617;
  localparam int FAR_LIM = 8192;
  localparam int ELL_A   = 2539;
  localparam int ELL_B   = 1403;
  localparam longint unsigned ELL_LIM =
    (64'(ELL_A) * 64'(ELL_A) * 64'(ELL_B) * 64'(ELL_B) * 64'd65536) / 64'd10000;

endpackage

[src/spec_chroma_corr.sv]
module spec_chroma_corr (
  input  logic            clk,
  input  logic            en,
  input  logic [7:0]      yl,
  input  logic [7:0]      cb,
  input  logic [7:0]      cr,
  output spec_pkg::ct_t   ctb,
  output spec_pkg::ct_t   ctr
);

  spec_pkg::ct_t ct_out [2];

  assign ctb = ct_out[0];
  assign ctr = ct_out[1];

  for (genvar g = 0; g < 2; g++) begin : g_lane
    localparam logic signed [17:0] CN0L = 18'(spec_pkg::CN0_LO[g]);
    localparam logic signed [17:0] CNSL = 18'(spec_pkg::CNS_LO[g]);
    localparam logic signed [17:0] CN0H = 18'(spec_pkg::CN0_HI[g]);
    localparam logic signed [17:0] CNSH = 18'(spec_pkg::CNS_HI[g]);
    localparam logic signed [20:0] SN0L = 21'(spec_pkg::SN0_LO[g]);
    localparam logic signed [20:0] SNSL = 21'(spec_pkg::SNS_LO[g]);
    localparam logic signed [20:0] SN0H = 21'(spec_pkg::SN0_HI[g]);
    localparam logic signed [20:0] SNSH = 21'(spec_pkg::SNS_HI[g]);
    localparam logic signed [20:0] K256 = 21'(spec_pkg::LANE_K[g] * 256);
    localparam int W = spec_pkg::LANE_W[g];

    logic [7:0] c_in;
    assign c_in = (g == 0) ? cb : cr;

    // stage a: center, spread and numerator from luma
    logic               lo, hi;
    logic signed [8:0]  t_s, u_s;
    logic signed [17:0] cn_s, num_s, dd_s;
    logic signed [20:0] sn_s;
    logic signed [17:0] num_r;
    logic signed [20:0] sn_r;
    logic               byp_a_r;
    logic [7:0]         c_a_r;

    always_comb begin
      lo    = yl < spec_pkg::LUMA_LO;
      hi    = yl > spec_pkg::LUMA_HI;
      t_s   = lo ? $signed({1'b0, spec_pkg::LUMA_LO}) - $signed({1'b0, yl})
                 : $signed({1'b0, yl}) - $signed({1'b0, spec_pkg::LUMA_HI});
      u_s   = lo ? $signed({1'b0, yl}) - $signed({1'b0, spec_pkg::SPREAD_LO_REF})
                 : $signed({1'b0, spec_pkg::SPREAD_HI_REF}) - $signed({1'b0, yl});
      cn_s  = lo ? CN0L + CNSL * 18'(t_s) : CN0H + CNSH * 18'(t_s);
      sn_s  = lo ? SN0L + SNSL * 21'(u_s) : SN0H + SNSH * 21'(u_s);
      dd_s  = lo ? 18'(spec_pkg::DEN_LO) : 18'(spec_pkg::DEN_HI);
      num_s = $signed({10'd0, c_in}) * dd_s - cn_s;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r   <= num_s;
        sn_r    <= sn_s;
        byp_a_r <= !lo && !hi;
        c_a_r   <= c_in;
      end
    end

    // stage b: magnitudes and scaled numerator
    logic [15:0] an;
    logic [28:0] aw_r;
    logic [18:0] ad_r;
    logic        neg_b_r, byp_b_r;
    logic [7:0]  c_b_r;
    logic [17:0] num_mag;
    logic [20:0] sn_mag;

    always_comb begin
      num_mag = num_r[17] ? 18'(-num_r) : 18'(num_r);
      sn_mag  = sn_r[20] ? 21'(-sn_r) : 21'(sn_r);
      an      = num_mag[15:0];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        aw_r    <= 29'(an * W);
        ad_r    <= sn_mag[18:0];
        neg_b_r <= num_r[17] ^ sn_r[20];
        byp_b_r <= byp_a_r;
        c_b_r   <= c_a_r;
      end
    end

    // stage c: rounding bias, divisor, overflow of the quotient range
    logic [37:0] nn;
    logic [19:0] dv0;
    logic        ovf0;

    logic [19:0] rem_r [spec_pkg::DIV_BITS+1];
    logic [18:0] nlo_r [spec_pkg::DIV_BITS+1];
    logic [18:0] q_r   [spec_pkg::DIV_BITS+1];
    logic [19:0] dv_r  [spec_pkg::DIV_BITS+1];
    logic        ovf_r [spec_pkg::DIV_BITS+1];
    logic        neg_r [spec_pkg::DIV_BITS+1];
    logic        byp_r [spec_pkg::DIV_BITS+1];
    logic [7:0]  c_r   [spec_pkg::DIV_BITS+1];

    always_comb begin
      nn   = {aw_r, 9'd0} + 38'(ad_r);
      dv0  = {ad_r, 1'b0};
      ovf0 = {1'b0, nn[37:19]} >= dv0;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[0] <= ovf0 ? '0 : {1'b0, nn[37:19]};
        nlo_r[0] <= nn[18:0];
        q_r[0]   <= '0;
        dv_r[0]  <= dv0;
        ovf_r[0] <= ovf0;
        neg_r[0] <= neg_b_r;
        byp_r[0] <= byp_b_r;
        c_r[0]   <= c_b_r;
      end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < spec_pkg::DIV_BITS; k++) begin : g_step
      logic [20:0] tt;
      logic        ge;
      logic [19:0] rem_nxt;

      always_comb begin
        tt      = {rem_r[k], nlo_r[k][18]};
        ge      = tt >= {1'b0, dv_r[k]};
        rem_nxt = ge ? 20'(tt - {1'b0, dv_r[k]}) : tt[19:0];
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= rem_nxt;
          nlo_r[k+1] <= {nlo_r[k][17:0], 1'b0};
          q_r[k+1]   <= {q_r[k][17:0], ge};
          dv_r[k+1]  <= dv_r[k];
          ovf_r[k+1] <= ovf_r[k];
          neg_r[k+1] <= neg_r[k];
          byp_r[k+1] <= byp_r[k];
          c_r[k+1]   <= c_r[k];
        end
      end
    end

    // stage d: bypass, sign, cluster offset and saturation
    localparam int L = spec_pkg::DIV_BITS;
    logic signed [20:0] sq, vv;
    spec_pkg::ct_t      ct_nxt, ct_r;

    always_comb begin
      sq = neg_r[L] ? -$signed({2'b00, q_r[L]}) : $signed({2'b00, q_r[L]});
      vv = sq + K256;
      if (byp_r[L]) begin
        ct_nxt = $signed({3'b000, c_r[L], 8'd0});
      end else if (ovf_r[L]) begin
        ct_nxt = neg_r[L] ? 19'(spec_pkg::CT_MIN) : 19'(spec_pkg::CT_MAX);
      end else if (vv > 21'(spec_pkg::CT_MAX)) begin
        ct_nxt = 19'(spec_pkg::CT_MAX);
      end else if (vv < 21'(spec_pkg::CT_MIN)) begin
        ct_nxt = 19'(spec_pkg::CT_MIN);
      end else begin
        ct_nxt = 19'(vv);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ct_r <= ct_nxt;
      end
    end

    assign ct_out[g] = ct_r;
  end

endmodule

[src/skin_pixel_ellipse_classifier.sv]
// path: an accepted input beat passes through the pipeline stages, then the output register
// throughput: one pixel per clock while the pipe is not stalled; the 19-stage restoring divider of the
//   chroma correction sets the depth, every stage takes a new pixel each cycle that it is enabled
// backpressure: an output register plus one skid entry; the pipe stalls as a
//   whole only while the skid entry is occupied
// reset: rst_n synchronous, active low; clears all valid bits, no data reset
module skin_pixel_ellipse_classifier (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red_level[7:0], green_level[15:8], blue_level[23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // skin_flag[0], zero fill [7:1]
);

  localparam int NP = spec_pkg::PIPE_STG;
  localparam int CE = 2 + spec_pkg::CORR_STG;  // last stage of the correction

  logic          en;
  logic [NP:1]   valid_r;
  logic          out_valid_r, skid_valid_r;
  logic          out_skin_r, skid_skin_r;

  assign en         = !skid_valid_r;
  assign in_tready  = en;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_skin_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[NP-1:1], in_tvalid};
    end
  end

  // stage 1: conversion products
  logic [7:0]  r_in, g_in, b_in;
  logic [23:0] p_yr_r, p_yg_r, p_yb_r, p_br_r, p_bg_r, p_rg_r, p_rb_r;
  logic [7:0]  r1_r, b1_r;

  assign r_in = in_tdata[7:0];
  assign g_in = in_tdata[15:8];
  assign b_in = in_tdata[23:16];

  always_ff @(posedge clk) begin
    if (en) begin
      p_yr_r <= 24'(spec_pkg::Y_R * r_in);
      p_yg_r <= 24'(spec_pkg::Y_G * g_in);
      p_yb_r <= 24'(spec_pkg::Y_B * b_in);
      p_br_r <= 24'(spec_pkg::CB_R * r_in);
      p_bg_r <= 24'(spec_pkg::CB_G * g_in);
      p_rg_r <= 24'(spec_pkg::CR_G * g_in);
      p_rb_r <= 24'(spec_pkg::CR_B * b_in);
      r1_r   <= r_in;
      b1_r   <= b_in;
    end
  end

  // stage 2: sums, truncated to 8 bits
  logic [24:0] ysum, cbsum, crsum;
  logic [7:0]  yl_r, cb_r, cr_r;

  always_comb begin
    ysum  = 25'(p_yr_r) + 25'(p_yg_r) + 25'(p_yb_r);
    cbsum = 25'(spec_pkg::CHROMA_OFS) + {2'b00, b1_r, 15'd0} - 25'(p_br_r) - 25'(p_bg_r);
    crsum = 25'(spec_pkg::CHROMA_OFS) + {2'b00, r1_r, 15'd0} - 25'(p_rg_r) - 25'(p_rb_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yl_r <= ysum[23:16];
      cb_r <= cbsum[23:16];
      cr_r <= crsum[23:16];
    end
  end

  // stages 3 to 25: luma dependent chroma correction
  spec_pkg::ct_t ctb, ctr;

  spec_chroma_corr u_corr (
    .clk (clk),
    .en  (en),
    .yl  (yl_r),
    .cb  (cb_r),
    .cr  (cr_r),
    .ctb (ctb),
    .ctr (ctr)
  );

  // stage 26: shift to the cluster center
  logic signed [19:0] dx_r, dy_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= 20'(ctb) - 20'(spec_pkg::CEN_B);
      dy_r <= 20'(ctr) - 20'(spec_pkg::CEN_R);
    end
  end

  // stage 27: rotation products
  logic signed [33:0] pcdx_r, psdy_r, pcdy_r, psdx_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pcdx_r <= 34'(dx_r) * 34'(spec_pkg::ROT_COS);
      psdy_r <= 34'(dy_r) * 34'(spec_pkg::ROT_SIN);
      pcdy_r <= 34'(dy_r) * 34'(spec_pkg::ROT_COS);
      psdx_r <= 34'(dx_r) * 34'(spec_pkg::ROT_SIN);
    end
  end

  // stage 28: rotated point, rounded back to q8.8, ellipse offset
  logic signed [34:0] xs, ys, xsh, ysh;
  logic signed [21:0] xr_r, yr_r;

  always_comb begin
    xs  = 35'(psdy_r) - 35'(pcdx_r) + 35'sd8192;
    ys  = -35'(pcdy_r) - 35'(psdx_r) + 35'sd8192;
    xsh = xs >>> 14;
    ysh = ys >>> 14;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr_r <= 22'(xsh) - 22'(spec_pkg::OFS_X);
      yr_r <= 22'(ysh) - 22'(spec_pkg::OFS_Y);
    end
  end

  // stage 29: far test, axis scaling
  logic               near;
  logic signed [21:0] ax_s, ay_s;
  logic [13:0]        ax, ay;
  logic [23:0]        u_r;
  logic [24:0]        v_r;
  logic               near_r;

  always_comb begin
    near = (xr_r <= 22'(spec_pkg::FAR_LIM)) && (xr_r >= -22'(spec_pkg::FAR_LIM)) &&
           (yr_r <= 22'(spec_pkg::FAR_LIM)) && (yr_r >= -22'(spec_pkg::FAR_LIM));
    ax_s = xr_r[21] ? -xr_r : xr_r;
    ay_s = yr_r[21] ? -yr_r : yr_r;
    ax   = ax_s[13:0];
    ay   = ay_s[13:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r    <= 24'(ax * spec_pkg::ELL_B);
      v_r    <= 25'(ay * spec_pkg::ELL_A);
      near_r <= near;
    end
  end

  // stage 30: squares
  logic [47:0] uu_r;
  logic [49:0] vv_r;
  logic        near2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      uu_r    <= u_r * u_r;
      vv_r    <= v_r * v_r;
      near2_r <= near_r;
    end
  end

  // output register with one skid entry
  logic pipe_out_valid, skin;

  assign pipe_out_valid = valid_r[NP] && en;
  assign skin = near2_r && ((51'(uu_r) + 51'(vv_r)) <= 51'(spec_pkg::ELL_LIM));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        out_skin_r   <= skid_skin_r;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= pipe_out_valid;
        out_skin_r  <= skin;
      end
    end else if (pipe_out_valid) begin
      skid_valid_r <= 1'b1;
      skid_skin_r  <= skin;
    end
  end

  // the skid entry only fills behind a held output beat
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry occupied with empty output register");

  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready && valid_r[NP] && in_tready |=> skid_valid_r)
    else $error("finished pixel dropped while output stalled");

  a_far_not_skin: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r || out_tready) && !skid_valid_r && valid_r[NP] && !near2_r
    |=> out_tvalid && !out_tdata[0])
    else $error("pixel far from the ellipse flagged as skin");

  a_corr_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && valid_r[CE] |=> valid_r[CE+1])
    else $error("valid bit lost past the chroma correction");

endmodule

[sim/tb_skin_pixel_ellipse_classifier.sv]
module tb_skin_pixel_ellipse_classifier;

  localparam longint CT_HI = 262143;
  localparam longint CT_LO = -262144;
  localparam longint FAR_LIM = 8192;
  localparam longint ELL_AA = 6446521;  // 25.39^2 in units of 0.01^2
  localparam longint ELL_BB = 1968409;  // 14.03^2
  localparam longint ELL_RHS = ELL_AA * ELL_BB * 65536;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES = 40;

  typedef struct {
    logic [23:0] pixel;
    int unsigned phase;
    bit          drain;
  } pixel_item_t;

  typedef struct {
    logic [23:0] pixel;
    bit          skin;
  } skin_expect_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic [23:0] in_tdata = '0;
  logic        out_tready = 1'b0;
  wire         in_tready;
  wire         out_tvalid;
  wire  [7:0]  out_tdata;

  pixel_item_t  pixel_queue[$];
  skin_expect_t skin_expected[$];
  int unsigned  send_idle_pct[3] = '{7, 60, 0};
  int unsigned  recv_idle_pct[3] = '{60, 7, 0};
  int unsigned  idle_phase = 0;
  int unsigned  pixels_total = 0;
  int unsigned  pixels_accepted = 0;
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;

  logic         result_seen = 1'b0;
  logic         result_flag = 1'b0;

  skin_pixel_ellipse_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // luma-corrected chroma in signed q8.8
  function automatic longint corrected_chroma(input longint luma, input longint c,
                                              input bit is_cr);
    longint den, cn, sn, w, k, num, an, ad, q, ct;
    if (luma >= 125 && luma <= 188) return c * 256;
    w = is_cr ? 3876 : 4697;
    k = is_cr ? 154 : 108;
    if (luma < 125) begin
      den = 109;
      cn = is_cr ? 16786 - 10 * (125 - luma) : 11772 + 10 * (125 - luma);
      sn = is_cr ? 218000 + 1876 * (luma - 16) : 250700 + 2397 * (luma - 16);
    end else begin
      den = 47;
      cn = is_cr ? 7238 + 22 * (luma - 188) : 5076 + 10 * (luma - 188);
      sn = is_cr ? 47000 + 2876 * (235 - luma) : 65800 + 3297 * (235 - luma);
    end
    num = c * den - cn;
    if (sn == 0) return (num > 0) ? CT_HI : (num < 0) ? CT_LO : k * 256;
    num = num * w * 256;
    // round to nearest, ties away from zero; spread may be negative near full luma
    an = (num < 0) ? -num : num;
    ad = (sn < 0) ? -sn : sn;
    q = (2 * an + ad) / (2 * ad);
    ct = (((num < 0) != (sn < 0)) ? -q : q) + k * 256;
    if (ct > CT_HI) ct = CT_HI;
    if (ct < CT_LO) ct = CT_LO;
    return ct;
  endfunction

  function automatic bit skin_of_pixel(input logic [23:0] px);
    longint r, g, b, luma, cb, cr, dx, dy, xr, yr, lhs;
    r = px[7:0];
    g = px[15:8];
    b = px[23:16];
    luma = (19595 * r + 38470 * g + 7471 * b) >>> 16;
    cb = (8388608 + 32768 * b - 11058 * r - 21710 * g) >>> 16;
    cr = (8388608 + 32768 * r - 27439 * g - 5329 * b) >>> 16;
    dx = corrected_chroma(luma, cb, 1'b0) - 28001;
    dy = corrected_chroma(luma, cr, 1'b1) - 38917;
    // rotate by 2.53 rad, round to q8.8 with a floor shift
    xr = ((-13414 * dx + 9407 * dy + 8192) >>> 14) - 410;
    yr = ((-13414 * dy - 9407 * dx + 8192) >>> 14) - 617;
    if (xr > FAR_LIM || xr < -FAR_LIM || yr > FAR_LIM || yr < -FAR_LIM) return 1'b0;
    lhs = 10000 * (ELL_BB * xr * xr + ELL_AA * yr * yr);
    return lhs <= ELL_RHS;
  endfunction

  function automatic int clamp8(input int v);
    return (v < 0) ? 0 : (v > 255) ? 255 : v;
  endfunction

  task automatic add_pixel(input int r, input int g, input int b,
                           input int unsigned phase, input bit drain);
    pixel_item_t item;
    item.pixel = {b[7:0], g[7:0], r[7:0]};
    item.phase = phase;
    item.drain = drain;
    pixel_queue.push_back(item);
    pixels_total++;
  endtask

  // input driver
  always @(posedge clk) begin
    skin_expect_t e;
    logic         load;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        e.pixel = in_tdata;
        e.skin = skin_of_pixel(in_tdata);
        skin_expected.push_back(e);
        pixels_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        load = 1'b0;
        if (pixel_queue.size() != 0)
          if (!(pixel_queue[0].drain && skin_expected.size() != 0))
            if ($urandom_range(99) >= send_idle_pct[pixel_queue[0].phase])
              load = 1'b1;
        if (load) begin
          idle_phase = pixel_queue[0].phase;
          in_tdata <= pixel_queue[0].pixel;
          pixel_queue.pop_front();
        end
        in_tvalid <= load;
      end
    end
  end

  // result sink and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      result_seen <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct[idle_phase]);
      result_seen <= out_tvalid && out_tready;
      result_flag <= out_tdata[0];
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog expired, %0d results outstanding", $time,
                   skin_expected.size());
          $display("Some tests failed");
          $finish;
        end
      end
    end
  end

  // compare at the falling edge so every expectation of that edge is queued
  always @(negedge clk) begin
    skin_expect_t e;
    if (result_seen) begin
      if (skin_expected.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got skin_flag=%0b", $time,
                 result_flag);
        mismatches++;
      end else begin
        e = skin_expected.pop_front();
        if (result_flag !== e.skin) begin
          $display("%0t: pixel r=%0d g=%0d b=%0d skin_flag expected %0b, got %0b",
                   $time, e.pixel[7:0], e.pixel[15:8], e.pixel[23:16], e.skin,
                   result_flag);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int kind, r, g, b, base;
    // gray ramp across the luma band edges and into negative spread, then primary and secondary colours
    add_pixel(0, 0, 0, 0, 1'b0);
    add_pixel(124, 124, 124, 0, 1'b0);
    add_pixel(125, 125, 125, 0, 1'b0);
    add_pixel(188, 188, 188, 0, 1'b0);
    add_pixel(189, 189, 189, 0, 1'b0);
    add_pixel(250, 250, 250, 0, 1'b0);
    add_pixel(251, 251, 251, 0, 1'b0);
    add_pixel(255, 255, 255, 0, 1'b0);
    add_pixel(255, 0, 0, 0, 1'b0);
    add_pixel(0, 255, 0, 0, 1'b0);
    add_pixel(0, 0, 255, 0, 1'b0);
    add_pixel(255, 255, 0, 0, 1'b0);
    add_pixel(0, 255, 255, 0, 1'b0);
    add_pixel(255, 0, 255, 0, 1'b0);
    // typical skin tones, light and dark
    add_pixel(224, 172, 144, 0, 1'b0);
    add_pixel(198, 134, 66, 0, 1'b0);
    add_pixel(141, 85, 36, 0, 1'b0);
    add_pixel(255, 219, 172, 0, 1'b0);
    add_pixel(232, 190, 172, 0, 1'b0);
    add_pixel(180, 120, 100, 0, 1'b0);
    // strong chroma near full luma drives the corrected value into saturation
    add_pixel(255, 255, 200, 0, 1'b0);
    add_pixel(250, 255, 255, 0, 1'b0);
    add_pixel(255, 250, 0, 0, 1'b0);
    add_pixel(10, 0, 0, 0, 1'b0);

    for (int unsigned p = 0; p < 3; p++) begin
      for (int i = 0; i < 345; i++) begin
        kind = $urandom_range(9);
        if (kind < 4) begin
          r = $urandom_range(255);
          g = $urandom_range(255);
          b = $urandom_range(255);
        end else if (kind < 8) begin
          r = $urandom_range(255, 80);
          g = r * int'($urandom_range(90, 45)) / 100;
          b = g * int'($urandom_range(105, 35)) / 100;
          r = clamp8(r + int'($urandom_range(16)) - 8);
          g = clamp8(g + int'($urandom_range(16)) - 8);
          b = clamp8(b);
        end else begin
          base = $urandom_range(1) ? int'($urandom_range(70)) : int'($urandom_range(255, 185));
          r = clamp8(base + int'($urandom_range(50)) - 10);
          g = clamp8(base + int'($urandom_range(30)) - 20);
          b = clamp8(base + int'($urandom_range(30)) - 25);
        end
        add_pixel(r, g, b, p, (p != 0 && i == 0) || i == 170);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pixels_accepted < pixels_total) @(posedge clk);
    while (skin_expected.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
src/spec_pkg.sv
src/spec_chroma_corr.sv
src/skin_pixel_ellipse_classifier.sv
sim/tb_skin_pixel_ellipse_classifier.sv
